// ===== rtl/wsd_pkg.sv =====
`timescale 1ns / 1ps

package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_e;

  // result kinds
  localparam logic [2:0] KIND_DATA      = 3'd0;
  localparam logic [2:0] KIND_PING      = 3'd1;
  localparam logic [2:0] KIND_EMPTY_END = 3'd2;
  localparam logic [2:0] KIND_CLOSE     = 3'd3;
  localparam logic [2:0] KIND_ERROR     = 3'd4;

  // frame opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'ha;

  // short length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] payload_byte;
    logic [1:0] message_type;
    logic       last;
  } result_t;

endpackage

// ===== rtl/wsd_in_if.sv =====
`timescale 1ns / 1ps

interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/wsd_out_if.sv =====
`timescale 1ns / 1ps

interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] payload_byte;
  logic [1:0] message_type;
  logic       last;

  modport source (output valid, output kind, output payload_byte, output message_type,
                  output last, input ready);
  modport sink (input valid, input kind, input payload_byte, input message_type,
                input last, output ready);
endinterface

// ===== rtl/wsd_parser.sv =====
`timescale 1ns / 1ps

module wsd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  output logic             res_valid_o,
  output wsd_pkg::result_t res_o
);
  import wsd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        final_q, final_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  key_pos_q, key_pos_d;
  logic [1:0]  msg_q, msg_d;
  logic        stopped_q, stopped_d;

  logic        go;
  logic [63:0] len_shift;
  logic [63:0] len_final;
  logic [63:0] rem_dec;
  logic        len_done;
  logic        len_err;
  logic        hdr_done;
  logic        masked_now;
  logic        op_data;
  logic        op_close;
  logic        op_rsv;
  logic        op_msg;
  logic        len_zero;
  logic        pay_step;
  logic        pay_end;
  logic [7:0]  key_byte;
  logic [7:0]  unmasked;

  // decode of the current byte against the header state
  always_comb begin
    go         = step_i && !stopped_q;
    len_shift  = {rem_q[55:0], rx_byte_i};
    masked_now = (phase_q == PH_HDR1) ? rx_byte_i[7] : masked_q;
    len_done   = 1'b0;
    len_err    = 1'b0;
    len_final  = rem_q;
    if (go) begin
      if (phase_q == PH_HDR1 && rx_byte_i[6:0] != LEN_EXT16 &&
          rx_byte_i[6:0] != LEN_EXT64) begin
        len_done  = 1'b1;
        len_final = {57'd0, rx_byte_i[6:0]};
      end else if (phase_q == PH_EXT16 && cnt_q == 4'd1) begin
        len_done  = 1'b1;
        len_final = len_shift;
      end else if (phase_q == PH_EXT64 && cnt_q == 4'd7) begin
        len_done  = !len_shift[63];
        len_err   = len_shift[63];
        len_final = len_shift;
      end
    end
    hdr_done = (len_done && !masked_now) || (go && phase_q == PH_KEY && cnt_q == 4'd3);
    len_zero = (len_final == 64'd0);
    op_data  = (opcode_q <= OP_BINARY);
    op_close = (opcode_q == OP_CLOSE);
    op_rsv   = !op_data && !op_close && opcode_q != OP_PING && opcode_q != OP_PONG;
    op_msg   = (opcode_q == OP_TEXT) || (opcode_q == OP_BINARY);
    pay_step = go && phase_q == PH_PAYLOAD;
    rem_dec  = (rem_q != 64'd0) ? rem_q - 64'd1 : rem_q;
    pay_end  = (rem_dec == 64'd0);
    case (key_pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
    unmasked = rx_byte_i ^ key_byte;
  end

  // next state
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    final_d   = final_q;
    opcode_d  = opcode_q;
    masked_d  = masked_q;
    rem_d     = rem_q;
    key_d     = key_q;
    key_pos_d = key_pos_q;
    msg_d     = msg_q;
    stopped_d = stopped_q;
    if (go) begin
      unique case (phase_q)
        PH_HDR0: begin
          final_d  = rx_byte_i[7];
          opcode_d = rx_byte_i[3:0];
          phase_d  = PH_HDR1;
        end
        PH_HDR1: begin
          masked_d = rx_byte_i[7];
          key_d    = 32'd0;
          cnt_d    = 4'd0;
          rem_d    = len_final;
          if (rx_byte_i[6:0] == LEN_EXT16) begin
            rem_d   = 64'd0;
            phase_d = PH_EXT16;
          end else if (rx_byte_i[6:0] == LEN_EXT64) begin
            rem_d   = 64'd0;
            phase_d = PH_EXT64;
          end
        end
        PH_EXT16, PH_EXT64: begin
          rem_d = len_shift;
          cnt_d = cnt_q + 4'd1;
          if (len_err) begin
            stopped_d = 1'b1;
          end
        end
        PH_KEY: begin
          key_d = {key_q[23:0], rx_byte_i};
          cnt_d = cnt_q + 4'd1;
        end
        PH_PAYLOAD: begin
          key_pos_d = key_pos_q + 2'd1;
          rem_d     = rem_dec;
          if (pay_end) begin
            phase_d = PH_HDR0;
            if (op_data && final_q) begin
              msg_d = 2'd0;
            end
          end
        end
        default: phase_d = PH_HDR0;
      endcase
    end
    if (len_done) begin
      cnt_d = 4'd0;
      if (masked_now) begin
        phase_d = PH_KEY;
      end
    end
    if (hdr_done) begin
      if (op_close || op_rsv) begin
        stopped_d = 1'b1;
      end else begin
        if (op_msg) begin
          msg_d = opcode_q[1:0];
        end
        key_pos_d = 2'd0;
        if (len_zero) begin
          phase_d = PH_HDR0;
          if (op_data && final_q) begin
            msg_d = 2'd0;
          end
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
    end
  end

  // result of the current byte
  always_comb begin
    res_valid_o        = 1'b0;
    res_o.kind         = KIND_DATA;
    res_o.payload_byte = 8'd0;
    res_o.message_type = msg_q;
    res_o.last         = 1'b0;
    if (len_err) begin
      res_valid_o = 1'b1;
      res_o.kind  = KIND_ERROR;
    end else if (hdr_done) begin
      if (op_close) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_CLOSE;
      end else if (op_rsv) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_ERROR;
      end else if (len_zero && op_data && final_q) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_EMPTY_END;
        res_o.last  = 1'b1;
        if (op_msg) begin
          res_o.message_type = opcode_q[1:0];
        end
      end
    end else if (pay_step) begin
      if (op_data) begin
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_DATA;
        res_o.payload_byte = unmasked;
        res_o.last         = pay_end && final_q;
      end else if (opcode_q == OP_PING) begin
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_PING;
        res_o.payload_byte = unmasked;
        res_o.last         = pay_end;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      cnt_q     <= 4'd0;
      final_q   <= 1'b0;
      opcode_q  <= OP_CONT;
      masked_q  <= 1'b0;
      rem_q     <= 64'd0;
      key_q     <= 32'd0;
      key_pos_q <= 2'd0;
      msg_q     <= 2'd0;
      stopped_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      final_q   <= final_d;
      opcode_q  <= opcode_d;
      masked_q  <= masked_d;
      rem_q     <= rem_d;
      key_q     <= key_d;
      key_pos_q <= key_pos_d;
      msg_q     <= msg_d;
      stopped_q <= stopped_d;
    end
  end

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q)
    else $error("stop flag cleared without reset");

  a_stop_on_fatal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == KIND_CLOSE || res_o.kind == KIND_ERROR) |=> stopped_q)
    else $error("close or error reported without stopping");

  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> rem_q != 64'd0)
    else $error("payload phase with no bytes left");

  a_no_result_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> !res_valid_o)
    else $error("result produced while stopped");

  a_msg_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.message_type != 2'd3)
    else $error("invalid message type");

endmodule

// ===== rtl/wsd_out_reg.sv =====
`timescale 1ns / 1ps

module wsd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  wsd_pkg::result_t res_i,
  input  logic             step_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             ready_i,
  output wsd_pkg::result_t res_o
);
  import wsd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // a held result may leave in the same cycle a new request comes in
  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (step_i && res_valid_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
// a result is registered and appears on tx_o in the cycle after the byte that causes it is taken
// throughput: one byte per cycle when not stalled, set by the single header/payload state update
// rx_i stalls only while a result waits in the output register and tx_o is not ready
// reset clears the frame state, the running/stopped flag and the output valid
// after a close or protocol error every byte is taken and dropped until reset

module websocket_frame_deframer (
  input logic        clk_i,
  input logic        rst_ni,
  wsd_in_if.sink     rx_i,
  wsd_out_if.source  tx_o
);
  import wsd_pkg::*;

  logic    step;
  logic    space;
  logic    res_valid;
  result_t res;
  result_t res_out;

  assign rx_i.ready = space;
  assign step       = rx_i.valid && space;

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (rx_i.rx_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .step_i      (step),
    .space_o     (space),
    .valid_o     (tx_o.valid),
    .ready_i     (tx_o.ready),
    .res_o       (res_out)
  );

  assign tx_o.kind         = res_out.kind;
  assign tx_o.payload_byte = res_out.payload_byte;
  assign tx_o.message_type = res_out.message_type;
  assign tx_o.last         = res_out.last;

endmodule

// ===== test/wsd_deframe_checker.sv =====
`timescale 1ns / 1ps

module wsd_deframe_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  wsd_in_if           rx_i,
  wsd_out_if          tx_i,
  output int unsigned err_count_o,
  output int unsigned outstanding_o,
  output int unsigned results_seen_o,
  output int unsigned bytes_taken_o
);
  import wsd_pkg::*;

  // shadow copy of the deframer state
  phase_e      phase;
  logic [3:0]  hdr_count;
  logic        fin;
  logic [3:0]  opcode;
  logic        masked;
  logic [63:0] remaining;
  logic [31:0] key;
  logic [1:0]  key_pos;
  logic [1:0]  msg_op;
  logic        halted;

  result_t     predicted_results[$];
  int unsigned errors;
  int unsigned results_seen;
  int unsigned bytes_taken;

  function automatic result_t pack_result(logic [2:0] k, logic [7:0] d, logic l);
    result_t r;
    r.kind         = k;
    r.payload_byte = d;
    r.message_type = msg_op;
    r.last         = l;
    return r;
  endfunction

  task automatic finish_header(output bit produced, output result_t res);
    produced = 1'b0;
    res      = '0;
    if (opcode == OP_CLOSE) begin
      halted   = 1'b1;
      produced = 1'b1;
      res      = pack_result(KIND_CLOSE, 8'h00, 1'b0);
    end else if (opcode > OP_BINARY && opcode != OP_PING && opcode != OP_PONG) begin
      halted   = 1'b1;
      produced = 1'b1;
      res      = pack_result(KIND_ERROR, 8'h00, 1'b0);
    end else begin
      if (opcode == OP_TEXT || opcode == OP_BINARY) msg_op = opcode[1:0];
      key_pos = 2'd0;
      if (remaining == 64'd0) begin
        phase = PH_HDR0;
        // empty final data frame closes the message on its own
        if (opcode <= OP_BINARY && fin) begin
          produced = 1'b1;
          res      = pack_result(KIND_EMPTY_END, 8'h00, 1'b1);
          msg_op   = 2'd0;
        end
      end else begin
        phase = PH_PAYLOAD;
      end
    end
  endtask

  task automatic close_length(output bit produced, output result_t res);
    produced  = 1'b0;
    res       = '0;
    hdr_count = 4'd0;
    if (masked) phase = PH_KEY;
    else finish_header(produced, res);
  endtask

  task automatic deframe_byte(input logic [7:0] b, output bit produced, output result_t res);
    logic [7:0] data;
    logic       at_end;
    logic       is_last;
    produced = 1'b0;
    res      = '0;
    if (halted) return;
    case (phase)
      PH_HDR0: begin
        fin    = b[7];
        opcode = b[3:0];
        phase  = PH_HDR1;
      end
      PH_HDR1: begin
        masked    = b[7];
        key       = 32'd0;
        hdr_count = 4'd0;
        remaining = 64'd0;
        if (b[6:0] == LEN_EXT16) phase = PH_EXT16;
        else if (b[6:0] == LEN_EXT64) phase = PH_EXT64;
        else begin
          remaining = {57'd0, b[6:0]};
          close_length(produced, res);
        end
      end
      PH_EXT16, PH_EXT64: begin
        remaining = {remaining[55:0], b};
        hdr_count = hdr_count + 4'd1;
        if (phase == PH_EXT16 && hdr_count >= 4'd2) begin
          close_length(produced, res);
        end else if (phase == PH_EXT64 && hdr_count >= 4'd8) begin
          // a length with the top bit set is refused before any key byte
          if (remaining[63]) begin
            halted   = 1'b1;
            produced = 1'b1;
            res      = pack_result(KIND_ERROR, 8'h00, 1'b0);
          end else begin
            close_length(produced, res);
          end
        end
      end
      PH_KEY: begin
        key       = {key[23:0], b};
        hdr_count = hdr_count + 4'd1;
        if (hdr_count >= 4'd4) finish_header(produced, res);
      end
      PH_PAYLOAD: begin
        data    = b ^ key[8 * (3 - key_pos) +: 8];
        key_pos = key_pos + 2'd1;
        if (remaining != 64'd0) remaining = remaining - 64'd1;
        at_end = (remaining == 64'd0);
        if (at_end) phase = PH_HDR0;
        if (opcode <= OP_BINARY) begin
          is_last  = at_end && fin;
          produced = 1'b1;
          res      = pack_result(KIND_DATA, data, is_last);
          if (is_last) msg_op = 2'd0;
        end else if (opcode == OP_PING) begin
          produced = 1'b1;
          res      = pack_result(KIND_PING, data, at_end);
        end
      end
      default: phase = PH_HDR0;
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bit      produced;
    result_t res;
    result_t want;
    if (!rst_ni) begin
      phase     = PH_HDR0;
      hdr_count = 4'd0;
      fin       = 1'b0;
      opcode    = 4'd0;
      masked    = 1'b0;
      remaining = 64'd0;
      key       = 32'd0;
      key_pos   = 2'd0;
      msg_op    = 2'd0;
      halted    = 1'b0;
      predicted_results.delete();
      errors       = 0;
      results_seen = 0;
      bytes_taken  = 0;
    end else begin
      if (rx_i.valid && rx_i.ready) begin
        bytes_taken++;
        deframe_byte(rx_i.rx_byte, produced, res);
        if (produced) predicted_results.push_back(res);
      end
      if (tx_i.valid && tx_i.ready) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, %s %0d byte %02h type %0d last %0d",
                   $time, "actual kind", tx_i.kind, tx_i.payload_byte, tx_i.message_type,
                   tx_i.last);
        end else begin
          want = predicted_results.pop_front();
          check_field("kind", 8'(want.kind), 8'(tx_i.kind));
          check_field("payload_byte", want.payload_byte, tx_i.payload_byte);
          check_field("message_type", 8'(want.message_type), 8'(tx_i.message_type));
          check_field("last", 8'(want.last), 8'(tx_i.last));
        end
      end
    end
    err_count_o    <= errors;
    outstanding_o  <= predicted_results.size();
    results_seen_o <= results_seen;
    bytes_taken_o  <= bytes_taken;
  end

endmodule

// ===== test/websocket_frame_deframer_test.sv =====
`timescale 1ns / 1ps

module websocket_frame_deframer_test;
  import wsd_pkg::*;

  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TARGET_BYTES = 1150;

  typedef enum int {FORM_SHORT, FORM_16, FORM_64} len_form_e;
  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE} rx_mode_e;

  logic clk_i;
  logic rst_ni;

  wsd_in_if  rx_bus ();
  wsd_out_if tx_bus ();

  int unsigned err_count;
  int unsigned outstanding;
  int unsigned results_seen;
  int unsigned bytes_taken;

  int unsigned burst_left;
  int unsigned live_bytes;
  int unsigned frames_sent;
  int unsigned stall_cycles;

  websocket_frame_deframer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_bus),
    .tx_o   (tx_bus)
  );

  wsd_deframe_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_i           (rx_bus),
    .tx_i           (tx_bus),
    .err_count_o    (err_count),
    .outstanding_o  (outstanding),
    .results_seen_o (results_seen),
    .bytes_taken_o  (bytes_taken)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // bursts of bytes with random gaps between them
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        rx_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 16);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_bus.ready) @(posedge clk_i);
    burst_left--;
  endtask

  // fill below zero means random payload bytes
  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                            input logic masked, input int unsigned len, input len_form_e form,
                            input int fill);
    logic [63:0] len64;
    logic [31:0] mask_bytes;
    int unsigned ext;
    len64      = 64'(len);
    mask_bytes = $urandom;
    ext        = 0;
    send_byte({fin, rsv, op});
    case (form)
      FORM_16: begin
        ext = 2;
        send_byte({masked, LEN_EXT16});
        send_byte(len64[15:8]);
        send_byte(len64[7:0]);
      end
      FORM_64: begin
        ext = 8;
        send_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len64[8 * i +: 8]);
      end
      default: send_byte({masked, len64[6:0]});
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(mask_bytes[8 * i +: 8]);
    end
    repeat (len) send_byte((fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0]);
    if (op != OP_PONG) live_bytes += 2 + ext + (masked ? 4 : 0) + len;
    frames_sent++;
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 80) return $urandom_range(1, 12);
    if (r < 95) return $urandom_range(13, 125);
    return $urandom_range(126, 300);
  endfunction

  // short lengths still go out in the longer encodings now and then
  function automatic len_form_e pick_form(input int unsigned len);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (len > 125) return (r < 70) ? FORM_16 : FORM_64;
    if (r < 80) return FORM_SHORT;
    if (r < 92) return FORM_16;
    return FORM_64;
  endfunction

  task automatic send_random_frame(input logic fin, input logic [3:0] op);
    int unsigned len;
    logic [2:0]  rsv;
    len = pick_len();
    rsv = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : 3'b000;
    send_frame(fin, rsv, op, $urandom_range(0, 3) != 0, len, pick_form(len), -1);
  endtask

  // a text or binary message, possibly fragmented, with pings slipped in between
  task automatic send_message();
    int unsigned pieces;
    logic [3:0]  op;
    pieces = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(2, 4);
    op     = ($urandom_range(0, 1) == 0) ? OP_TEXT : OP_BINARY;
    for (int i = 0; i < pieces; i++) begin
      send_random_frame(i == pieces - 1, (i == 0) ? op : OP_CONT);
      if ($urandom_range(0, 3) == 0) send_random_frame($urandom_range(0, 3) != 0, OP_PING);
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_random_frame(1'b1, OP_PONG);
      1: send_random_frame(1'($urandom_range(0, 1)), OP_CONT);
      2: send_random_frame(1'b0, ($urandom_range(0, 1) == 0) ? OP_TEXT : OP_BINARY);
      default: send_frame(1'b1, 3'b000, OP_PING, 1'($urandom_range(0, 1)), 0, FORM_SHORT, -1);
    endcase
  endtask

  initial begin : stimulus
    string       ending;
    logic [3:0]  bad_op;
    rst_ni         <= 1'b0;
    rx_bus.valid   <= 1'b0;
    rx_bus.rx_byte <= 8'h00;
    burst_left  = 0;
    live_bytes  = 0;
    frames_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_frame(1'b1, 3'b000, OP_TEXT, 1'b0, 1, FORM_SHORT, 8'hff);
    send_frame(1'b0, 3'b111, OP_BINARY, 1'b1, 2, FORM_SHORT, 8'h00);
    send_frame(1'b1, 3'b000, OP_CONT, 1'b0, 0, FORM_SHORT, -1);
    send_frame(1'b1, 3'b000, OP_PING, 1'b0, 1, FORM_SHORT, 8'h00);
    send_frame(1'b1, 3'b000, OP_PONG, 1'b0, 1, FORM_SHORT, 8'h55);
    send_frame(1'b1, 3'b000, OP_PING, 1'b0, 0, FORM_SHORT, -1);
    // continuation with no message open, in a non-minimal 16-bit length
    send_frame(1'b1, 3'b000, OP_CONT, 1'b0, 1, FORM_16, 8'h5a);

    while (live_bytes < TARGET_BYTES) begin
      if ($urandom_range(0, 3) != 0) send_message();
      else send_noise();
    end

    // the stop is sticky, so only one way of stopping fits in a run
    case ($urandom_range(0, 2))
      0: begin
        ending = "a close frame";
        send_frame(1'b1, 3'b000, OP_CLOSE, 1'($urandom_range(0, 1)), $urandom_range(0, 6),
                   FORM_SHORT, -1);
      end
      1: begin
        ending = "a reserved opcode";
        bad_op = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(3, 7)) :
                                               4'($urandom_range(11, 15));
        send_frame(1'($urandom_range(0, 1)), 3'b000, bad_op, 1'($urandom_range(0, 1)),
                   $urandom_range(0, 4), FORM_SHORT, -1);
      end
      default: begin
        ending = "an oversized 64-bit length";
        send_byte({1'b1, 3'b000, OP_BINARY});
        send_byte({1'($urandom_range(0, 1)), LEN_EXT64});
        send_byte(8'h80 | 8'($urandom_range(0, 255)));
        repeat (7) send_byte(8'($urandom_range(0, 255)));
      end
    endcase
    repeat (12) send_byte(8'($urandom_range(0, 255)));
    rx_bus.valid <= 1'b0;

    do @(posedge clk_i); while (outstanding != 0);
    repeat (10) @(posedge clk_i);

    $display("run covered %0d frames, %0d bytes taken, %0d results checked",
             frames_sent, bytes_taken, results_seen);
    $display("stream was stopped by %s, with later bytes dropped", ending);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // receiver stalls in stretches of its own, with one long hold-off
  initial begin : rx_side
    rx_mode_e    mode;
    int unsigned stretch;
    bit          held;
    held = 1'b0;
    tx_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      mode    = rx_mode_e'($urandom_range(0, 2));
      stretch = $urandom_range(10, 120);
      repeat (stretch) begin
        @(posedge clk_i);
        if (!held && results_seen >= 200) begin
          held = 1'b1;
          tx_bus.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end
        case (mode)
          RX_OPEN: tx_bus.ready <= 1'b1;
          RX_HALF: tx_bus.ready <= ($urandom_range(0, 1) == 1);
          default: tx_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if ((rx_bus.valid && rx_bus.ready) || (tx_bus.valid && tx_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial stall_cycles = 0;

endmodule
